// File: src/mst_pkg.sv
// Shared constants for the minimum spanning tree engine.
`default_nettype none
package mst_pkg;
   // Default sizes of the engine.
   localparam int MST_MAX_VERTICES = 16;
   localparam int MST_WEIGHT_BITS  = 16;

   // Fixed field widths on the ports.
   localparam int MST_VERTEX_FIELD_BITS = 4;
   localparam int MST_WEIGHT_FIELD_BITS = 16;
   localparam int MST_COUNT_BITS        = 5;
   localparam logic [MST_COUNT_BITS-1:0] MST_COUNT_RESET = 5'd16;

   // Item modes.
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_RUN = 1'b1;
endpackage
`default_nettype wire

// File: src/mst_adj_store.sv
// Adjacency matrix memory with the vertex pair folded to one entry.
`default_nettype none
module mst_adj_store #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16,
   parameter int VW           = $clog2(MAX_VERTICES)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [VW-1:0]                 wr_a,
   input  wire logic [VW-1:0]                 wr_b,
   input  wire logic                          wr_present,
   input  wire logic signed [WEIGHT_BITS-1:0] wr_weight,
   input  wire logic [VW-1:0]                 rd_a,
   input  wire logic [VW-1:0]                 rd_b,
   output logic                               rd_present,
   output logic signed [WEIGHT_BITS-1:0]      rd_weight
);
   import mst_pkg::*;

   localparam int Depth = 1 << (2 * VW);

   logic [WEIGHT_BITS:0] mem [Depth];
   logic [2*VW-1:0]      wr_addr;
   logic [2*VW-1:0]      rd_addr;
   logic [WEIGHT_BITS:0] rd_data_ff;

   // An undirected edge lives once, under the lower endpoint first.
   assign wr_addr = (wr_a < wr_b) ? {wr_a, wr_b} : {wr_b, wr_a};
   assign rd_addr = (rd_a < rd_b) ? {rd_a, rd_b} : {rd_b, rd_a};

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_present, wr_weight};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_present = rd_data_ff[WEIGHT_BITS];
   assign rd_weight  = rd_data_ff[WEIGHT_BITS-1:0];
endmodule
`default_nettype wire

// File: src/minimum_spanning_tree_engine.sv
// Top level of the minimum spanning tree engine (Prim over an adjacency matrix).
//
//  channel | direction | handshake          | contents
//  req     | in        | req_valid/stall    | mode, vertex_a, vertex_b, edge_weight
//  rsp     | out       | rsp_valid/stall    | tree_vertex, tree_parent, tree_weight,
//          |           |                    | edge_valid, last
//  csr     | in        | csr_wr_en          | vertex_count
//
// Add-edge items may follow each other in every cycle while the engine is idle.
// For each vertex that it joins, a run scans the vertex record memory through its
// single read port, once to select and once to relax.
// After each run and after reset the matrix is swept clear, one entry a cycle, over all
// 2**(2*clog2(MAX_VERTICES)) entries (256 at the defaults); req_stall is high meanwhile.
// A stalled result waits in the output register; the run waits behind it.
`default_nettype none
module minimum_spanning_tree_engine #(
   parameter int MAX_VERTICES = mst_pkg::MST_MAX_VERTICES,
   parameter int WEIGHT_BITS  = mst_pkg::MST_WEIGHT_BITS
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              req_valid,
   output logic                                                   req_stall,
   input  wire logic                                              req_mode,
   input  wire logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]         req_vertex_a,
   input  wire logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]         req_vertex_b,
   input  wire logic signed [mst_pkg::MST_WEIGHT_FIELD_BITS-1:0]  req_edge_weight,
   output logic                                                   rsp_valid,
   input  wire logic                                              rsp_stall,
   output logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]              rsp_tree_vertex,
   output logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]              rsp_tree_parent,
   output logic signed [mst_pkg::MST_WEIGHT_FIELD_BITS-1:0]       rsp_tree_weight,
   output logic                                                   rsp_edge_valid,
   output logic                                                   rsp_last,
   input  wire logic                                              csr_wr_en,
   input  wire logic [mst_pkg::MST_COUNT_BITS-1:0]                csr_wr_data
);
   import mst_pkg::*;

   localparam int VW       = $clog2(MAX_VERTICES);
   localparam int NW       = VW + 1;
   localparam int CW       = 2 * VW + 1;
   localparam int XW       = (NW > MST_COUNT_BITS + 1) ? NW : MST_COUNT_BITS + 1;
   localparam int IW       = (NW > MST_VERTEX_FIELD_BITS + 1) ? NW : MST_VERTEX_FIELD_BITS + 1;
   localparam int AdjDepth = 1 << (2 * VW);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_SEL   = 3'd3;
   localparam logic [2:0] S_REL   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   typedef struct packed {
      logic                          in_tree;
      logic                          finite;
      logic                          has_par;
      logic signed [WEIGHT_BITS-1:0] key;
      logic [VW-1:0]                 parent;
   } vtx_rec_type;

   // Registers.
   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [NW-1:0]                 n_ff, n_in;
   logic [NW-1:0]                 it_ff, it_in;
   logic                          p_vld_ff;
   logic [VW-1:0]                 p_idx_ff;
   logic                          found_ff, found_in;
   vtx_rec_type                   best_ff, best_in;
   logic [VW-1:0]                 best_idx_ff, best_idx_in;
   logic                          pend_vld_ff, pend_vld_in;
   logic [VW-1:0]                 pend_v_ff, pend_v_in;
   logic [VW-1:0]                 pend_p_ff, pend_p_in;
   logic signed [WEIGHT_BITS-1:0] pend_w_ff, pend_w_in;
   logic                          out_vld_ff, out_vld_in;
   logic [VW-1:0]                 out_v_ff, out_v_in;
   logic [VW-1:0]                 out_p_ff, out_p_in;
   logic signed [WEIGHT_BITS-1:0] out_w_ff, out_w_in;
   logic                          out_ev_ff, out_ev_in;
   logic                          out_last_ff, out_last_in;
   logic [MST_COUNT_BITS-1:0]     vcount_ff;

   // Vertex record memory.
   vtx_rec_type                   vmem [MAX_VERTICES];
   vtx_rec_type                   vm_rdata_ff;
   logic                          vm_we;
   logic [VW-1:0]                 vm_waddr;
   vtx_rec_type                   vm_wdata;

   // Adjacency port.
   logic                          adj_we;
   logic [VW-1:0]                 adj_wa, adj_wb;
   logic                          adj_wp;
   logic signed [WEIGHT_BITS-1:0] adj_ww;
   logic                          adj_rp;
   logic signed [WEIGHT_BITS-1:0] adj_rw;

   logic                          issue;
   logic [VW-1:0]                 idx;
   logic                          scan_done;
   logic                          out_free;
   logic [XW-1:0]                 vc_x;
   logic [NW-1:0]                 n_clamped;
   logic [IW-1:0]                 a_x, b_x;
   logic                          add_ok;
   logic                          take;
   logic                          relax;

   mst_adj_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .VW           (VW)
   ) u_adj (
      .clock      (clock),
      .wr_en      (adj_we),
      .wr_a       (adj_wa),
      .wr_b       (adj_wb),
      .wr_present (adj_wp),
      .wr_weight  (adj_ww),
      .rd_a       (best_idx_ff),
      .rd_b       (idx),
      .rd_present (adj_rp),
      .rd_weight  (adj_rw)
   );

   // Common decode.
   assign idx       = cnt_ff[VW-1:0];
   assign issue     = ((state_ff == S_SEL) || (state_ff == S_REL)) && (cnt_ff < CW'(n_ff));
   assign scan_done = (cnt_ff == CW'(n_ff)) && !p_vld_ff;
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Vertex count clamped to the usable range.
   assign vc_x      = XW'(vcount_ff);
   assign n_clamped = (vc_x == '0) ? NW'(1) :
                      (vc_x > XW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_x);

   // An edge with an endpoint beyond the matrix is dropped.
   assign a_x    = IW'(req_vertex_a);
   assign b_x    = IW'(req_vertex_b);
   assign add_ok = (a_x < IW'(MAX_VERTICES)) && (b_x < IW'(MAX_VERTICES));

   // Selection takes the first free vertex, then any strictly smaller finite key.
   assign take = !vm_rdata_ff.in_tree &&
                 (!found_ff || (vm_rdata_ff.finite &&
                  (!best_ff.finite || (vm_rdata_ff.key < best_ff.key))));

   // Relaxation needs a present edge and a strictly smaller weight.
   assign relax = (p_idx_ff != best_idx_ff) && !vm_rdata_ff.in_tree && adj_rp &&
                  (!vm_rdata_ff.finite || (adj_rw < vm_rdata_ff.key));

   // Adjacency write: the clearing sweep or an accepted add item.
   always_comb begin
      adj_we = 1'b0;
      adj_wa = cnt_ff[2*VW-1:VW];
      adj_wb = cnt_ff[VW-1:0];
      adj_wp = 1'b0;
      adj_ww = '0;
      if (state_ff == S_CLEAR) begin
         adj_we = 1'b1;
      end else if ((state_ff == S_IDLE) && req_valid && (req_mode == MODE_ADD) && add_ok) begin
         adj_we = 1'b1;
         adj_wa = a_x[VW-1:0];
         adj_wb = b_x[VW-1:0];
         adj_wp = 1'b1;
         adj_ww = WEIGHT_BITS'(req_edge_weight);
      end
   end

   // Vertex record write: set-up pass, joining and relaxation.
   always_comb begin
      vm_we    = 1'b0;
      vm_waddr = p_idx_ff;
      vm_wdata = vm_rdata_ff;
      if ((state_ff == S_INIT) && (cnt_ff < CW'(n_ff))) begin
         vm_we    = 1'b1;
         vm_waddr = idx;
         vm_wdata = '{in_tree: 1'b0, finite: (cnt_ff == '0), has_par: 1'b0,
                      key: '0, parent: '0};
      end else if ((state_ff == S_REL) && p_vld_ff) begin
         if (p_idx_ff == best_idx_ff) begin
            vm_we            = 1'b1;
            vm_wdata.in_tree = 1'b1;
         end else if (relax) begin
            vm_we    = 1'b1;
            vm_wdata = '{in_tree: 1'b0, finite: 1'b1, has_par: 1'b1,
                         key: adj_rw, parent: best_idx_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vm_we) begin
         vmem[vm_waddr] <= vm_wdata;
      end
      vm_rdata_ff <= vmem[idx];
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      it_in       = it_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_v_in   = pend_v_ff;
      pend_p_in   = pend_p_ff;
      pend_w_in   = pend_w_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_v_in    = out_v_ff;
      out_p_in    = out_p_ff;
      out_w_in    = out_w_ff;
      out_ev_in   = out_ev_ff;
      out_last_in = out_last_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(AdjDepth - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && (req_mode == MODE_RUN)) begin
               n_in     = n_clamped;
               it_in    = '0;
               cnt_in   = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(n_ff - NW'(1))) begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (p_vld_ff && take) begin
               found_in    = 1'b1;
               best_in     = vm_rdata_ff;
               best_idx_in = p_idx_ff;
            end
            if (scan_done) begin
               cnt_in   = '0;
               state_in = S_REL;
            end
         end
         S_REL: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (scan_done) begin
               cnt_in   = '0;
               found_in = 1'b0;
               it_in    = it_ff + NW'(1);
               if (best_ff.has_par) begin
                  state_in = S_EMIT;
               end else if ((it_ff + NW'(1)) == n_ff) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_SEL;
               end
            end
         end
         S_EMIT: begin
            // The held result goes out once a newer one is known to follow it.
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_vld_in  = 1'b1;
                  out_v_in    = pend_v_ff;
                  out_p_in    = pend_p_ff;
                  out_w_in    = pend_w_ff;
                  out_ev_in   = 1'b1;
                  out_last_in = 1'b0;
               end
               pend_vld_in = 1'b1;
               pend_v_in   = best_idx_ff;
               pend_p_in   = best_ff.parent;
               pend_w_in   = best_ff.key;
               state_in    = (it_ff == n_ff) ? S_FIN : S_SEL;
            end
         end
         S_FIN: begin
            // Final item of the run, or the empty marker.
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_v_in    = pend_vld_ff ? pend_v_ff : '0;
               out_p_in    = pend_vld_ff ? pend_p_ff : '0;
               out_w_in    = pend_vld_ff ? pend_w_ff : '0;
               out_ev_in   = pend_vld_ff;
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               cnt_in      = '0;
               state_in    = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         cnt_ff      <= '0;
         p_vld_ff    <= 1'b0;
         found_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         vcount_ff   <= MST_COUNT_RESET;
         n_ff        <= NW'(1);
         it_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         p_vld_ff    <= issue;
         found_ff    <= found_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         n_ff        <= n_in;
         it_ff       <= it_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_idx_ff    <= idx;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      pend_v_ff   <= pend_v_in;
      pend_p_ff   <= pend_p_in;
      pend_w_ff   <= pend_w_in;
      out_v_ff    <= out_v_in;
      out_p_ff    <= out_p_in;
      out_w_ff    <= out_w_in;
      out_ev_ff   <= out_ev_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_tree_vertex = MST_VERTEX_FIELD_BITS'(out_v_ff);
   assign rsp_tree_parent = MST_VERTEX_FIELD_BITS'(out_p_ff);
   assign rsp_tree_weight = MST_WEIGHT_FIELD_BITS'(out_w_ff);
   assign rsp_edge_valid  = out_ev_ff;
   assign rsp_last        = out_last_ff;
endmodule
`default_nettype wire

// File: src/mst_checker.sv
// Port-level assertions for the minimum spanning tree engine, with their bind.
`default_nettype none
module mst_checker (
   input wire logic                                              clock,
   input wire logic                                              reset,
   input wire logic                                              req_stall,
   input wire logic                                              rsp_valid,
   input wire logic                                              rsp_stall,
   input wire logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]         rsp_tree_vertex,
   input wire logic [mst_pkg::MST_VERTEX_FIELD_BITS-1:0]         rsp_tree_parent,
   input wire logic signed [mst_pkg::MST_WEIGHT_FIELD_BITS-1:0]  rsp_tree_weight,
   input wire logic                                              rsp_edge_valid,
   input wire logic                                              rsp_last
);
   import mst_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tree_vertex) &&
      $stable(rsp_tree_parent) && $stable(rsp_tree_weight) &&
      $stable(rsp_edge_valid) && $stable(rsp_last))
      else $error("result changed while stalled");

   // The empty marker is always the final item of its run.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_edge_valid |-> rsp_last)
      else $error("empty result without last");

   // The empty marker carries zero fields.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_edge_valid |-> (rsp_tree_vertex == '0) &&
      (rsp_tree_parent == '0) && (rsp_tree_weight == '0))
      else $error("empty result with non-zero fields");

   // After reset the matrix is being cleared and nothing is shown.
   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_stall && !rsp_valid)
      else $error("engine open for items straight after reset");
endmodule

bind minimum_spanning_tree_engine mst_checker u_mst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_tree_vertex (rsp_tree_vertex),
   .rsp_tree_parent (rsp_tree_parent),
   .rsp_tree_weight (rsp_tree_weight),
   .rsp_edge_valid  (rsp_edge_valid),
   .rsp_last        (rsp_last)
);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the minimum spanning tree engine.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mst_pkg::*;

   localparam int NV = MST_MAX_VERTICES;
   localparam int STALL_LIMIT = 40000;

   // One tree edge as it appears on the result channel.
   typedef struct packed {
      logic [3:0]         vertex;
      logic [3:0]         parent;
      logic signed [15:0] weight;
      logic               edge_valid;
      logic               last;
   } tree_edge_type;

   // Scoreboard: a private copy of the engine's graph and the pending tree edges.
   class mst_scoreboard_type;
      logic signed [15:0] weight_of [NV][NV];
      bit                 linked [NV][NV];
      int unsigned        count_setting;
      tree_edge_type      pending_edges[$];
      int                 failures;
      int                 edges_seen;
      int                 runs_seen;

      function new();
         count_setting = MST_COUNT_RESET;
         foreach (linked[i, j]) linked[i][j] = 0;
         failures = 0;
         edges_seen = 0;
         runs_seen = 0;
      endfunction

      function void note_count(logic [4:0] value);
         count_setting = value;
      endfunction

      // Store an edge, or grow the tree and queue its edges.
      function void note_item(logic mode, logic [3:0] a, logic [3:0] b,
                              logic signed [15:0] w);
         int unsigned n, it, i, v;
         bit found;
         bit joined [NV];
         bit reached [NV];
         bit has_parent [NV];
         logic signed [15:0] key [NV];
         logic [3:0] parent [NV];
         int made;
         tree_edge_type e;
         if (mode == MODE_ADD) begin
            weight_of[a][b] = w;
            weight_of[b][a] = w;
            linked[a][b] = 1;
            linked[b][a] = 1;
            return;
         end
         runs_seen++;
         n = (count_setting == 0) ? 1 : (count_setting > NV ? NV : count_setting);
         for (i = 0; i < NV; i++) begin
            joined[i] = 0;
            reached[i] = 0;
            has_parent[i] = 0;
            key[i] = 0;
            parent[i] = 0;
         end
         reached[0] = 1;
         made = 0;
         for (it = 0; it < n; it++) begin
            found = 0;
            v = 0;
            // Pick the cheapest reached vertex, lowest index on a tie.
            for (i = 0; i < n; i++) begin
               if (!joined[i]) begin
                  if (!found) begin
                     v = i;
                     found = 1;
                  end else if (reached[i] && (!reached[v] || key[i] < key[v])) begin
                     v = i;
                  end
               end
            end
            if (!found) break;
            joined[v] = 1;
            // Relax neighbours, only on a strictly smaller weight.
            for (i = 0; i < n; i++) begin
               if (!joined[i] && linked[v][i] &&
                   (!reached[i] || weight_of[v][i] < key[i])) begin
                  key[i] = weight_of[v][i];
                  reached[i] = 1;
                  parent[i] = 4'(v);
                  has_parent[i] = 1;
               end
            end
            if (has_parent[v]) begin
               e.vertex = 4'(v);
               e.parent = parent[v];
               e.weight = key[v];
               e.edge_valid = 1;
               e.last = 0;
               pending_edges = {pending_edges, e};
               made++;
            end
         end
         if (made == 0) begin
            e = '0;
            e.last = 1;
            pending_edges = {pending_edges, e};
         end else begin
            e = pending_edges.pop_back();
            e.last = 1;
            pending_edges = {pending_edges, e};
         end
         foreach (linked[i, j]) linked[i][j] = 0;
      endfunction

      // Compare one result item with the oldest pending edge.
      function void check_edge(tree_edge_type got);
         tree_edge_type want;
         edges_seen++;
         if (pending_edges.size() == 0) begin
            $error("unexpected result item %p", got);
            failures++;
            return;
         end
         want = pending_edges.pop_front();
         if (got.vertex !== want.vertex) begin
            $error("tree_vertex expected %0d got %0d", want.vertex, got.vertex);
            failures++;
         end
         if (got.parent !== want.parent) begin
            $error("tree_parent expected %0d got %0d", want.parent, got.parent);
            failures++;
         end
         if (got.weight !== want.weight) begin
            $error("tree_weight expected %0d got %0d", want.weight, got.weight);
            failures++;
         end
         if (got.edge_valid !== want.edge_valid) begin
            $error("edge_valid expected %0b got %0b", want.edge_valid, got.edge_valid);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_mode = MODE_ADD;
   logic [3:0] req_vertex_a = 0;
   logic [3:0] req_vertex_b = 0;
   logic signed [15:0] req_edge_weight = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [3:0] rsp_tree_vertex;
   logic [3:0] rsp_tree_parent;
   logic signed [15:0] rsp_tree_weight;
   logic rsp_edge_valid;
   logic rsp_last;
   logic csr_wr_en = 0;
   logic [4:0] csr_wr_data = 0;

   mst_scoreboard_type tree_board = new();
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit hold_receiver = 0;
   int quiet_cycles = 0;

   minimum_spanning_tree_engine DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Receiver: random stalls, plus one long hold-off when asked.
   always @(negedge clock) begin
      int hold;
      if (hold_receiver) begin
         rsp_stall <= 1;
         for (hold = 0; hold < 3000; hold++) @(negedge clock);
         hold_receiver = 0;
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Sample results and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tree_board.check_edge({rsp_tree_vertex, rsp_tree_parent, rsp_tree_weight,
                                   rsp_edge_valid, rsp_last});
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Offer one item and hold it until accepted; the caller's next step sets valid.
   task automatic send_item(logic mode, logic [3:0] a, logic [3:0] b,
                            logic signed [15:0] w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_vertex_a <= a;
      req_vertex_b <= b;
      req_edge_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tree_board.note_item(mode, a, b, w);
      @(negedge clock);
   endtask

   // Stop offering items and wait until every expected result has come.
   task automatic drain();
      int k;
      req_valid <= 0;
      while (tree_board.pending_edges.size() != 0) @(negedge clock);
      for (k = 0; k < 20; k++) @(negedge clock);
   endtask

   // Vertex count is written only with nothing outstanding.
   task automatic write_count(logic [4:0] value);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 0;
      tree_board.note_count(value);
   endtask

   // A random graph over n vertices, then a run.
   task automatic random_graph(int n);
      int edges, k;
      logic signed [15:0] w;
      edges = $urandom_range(3 * n);
      for (k = 0; k < edges; k++) begin
         w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)) - 16'sd8;
         if ($urandom_range(15) == 0)
            send_item(MODE_ADD, 4'($urandom), 4'($urandom), w);
         else
            send_item(MODE_ADD, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)), w);
      end
      send_item(MODE_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
   endtask

   initial begin
      int phase, n, k;
      repeat (3) @(negedge clock);
      reset <= 0;

      // Directed part: extremes, ties, self loop, overwrite, forest, empty runs.
      send_item(MODE_RUN, 0, 0, 0);
      send_item(MODE_ADD, 0, 15, 16'sh7FFF);
      send_item(MODE_ADD, 15, 1, -16'sd32768);
      send_item(MODE_ADD, 2, 2, -16'sd5);
      send_item(MODE_ADD, 0, 3, 16'sd4);
      send_item(MODE_ADD, 3, 0, 16'sd9);
      send_item(MODE_ADD, 0, 4, 16'sd9);
      send_item(MODE_ADD, 5, 6, 16'sd1);
      send_item(MODE_ADD, 6, 7, 16'sd1);
      send_item(MODE_ADD, 5, 7, 16'sd1);
      send_item(MODE_RUN, 4'hF, 4'hF, -16'sd1);
      write_count(1);
      send_item(MODE_ADD, 0, 1, 16'sd3);
      send_item(MODE_RUN, 0, 0, 0);
      write_count(0);
      send_item(MODE_RUN, 0, 0, 0);
      write_count(2);
      send_item(MODE_ADD, 1, 0, -16'sd2);
      send_item(MODE_RUN, 0, 0, 0);
      write_count(31);
      send_item(MODE_ADD, 14, 15, 16'sh5555);
      send_item(MODE_ADD, 0, 14, -16'sh5556);
      send_item(MODE_RUN, 0, 0, 0);

      // Random part in three idling phases.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 70 : 0;
         receiver_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 32 : 0;
         for (k = 0; k < 10; k++) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(16) : $urandom_range(1, 6);
            write_count(5'(n));
            if (k == 3 && phase == 2) hold_receiver = 1;
            random_graph(n == 0 ? 1 : n);
            random_graph(n == 0 ? 1 : n);
            if (k == 5) drain();
         end
      end
      drain();
      $display("Covered %0d runs and %0d result items at several vertex counts.",
               tree_board.runs_seen, tree_board.edges_seen);
      if (tree_board.failures == 0 && tree_board.pending_edges.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
